// ===== rtl/core/packbits_rle_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// PackBits decoder assertion macros
// Shared concurrent assertion shorthands, clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef PACKBITS_RLE_DECODER_MACROS_SVH
`define PACKBITS_RLE_DECODER_MACROS_SVH

// Property checked only outside reset.
`define PBRLE_ASSERT_RUN(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("pbrle check failed");

// Property checked on every edge, reset included.
`define PBRLE_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("pbrle check failed");

`endif

// ===== rtl/core/pbrle_pkg.sv =====
// ----------------------------------------------------------------------------
// PackBits decoder package
// Shared types and constants of the PackBits decoder.
// ----------------------------------------------------------------------------
package pbrle_pkg;

    localparam int LimitWidth = 24;
    localparam logic [LimitWidth-1:0] LIMIT_RESET = 24'd320;
    localparam logic [7:0] HDR_NOP = 8'd128;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_DISCARD = 2'd2,
        PH_RUNVAL  = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t                phase;
        logic [7:0]            literal_left;
        logic [7:0]            discard_left;
        logic [7:0]            run_length;
        logic [LimitWidth-1:0] owed;
    } dec_state_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic [7:0] count;
        logic       last;
    } dec_result_t;

endpackage

// ===== rtl/core/pbrle_step.sv =====
// ----------------------------------------------------------------------------
// PackBits decode step
// Next state and optional result for one compressed word.
// ----------------------------------------------------------------------------
module pbrle_step (
    input  pbrle_pkg::dec_state_t                 state,
    input  logic [7:0]                            in_byte,
    input  logic [pbrle_pkg::LimitWidth-1:0]      limit_eff,
    output pbrle_pkg::dec_state_t                 state_next,
    output pbrle_pkg::dec_result_t                result
);

    logic [7:0]                       lit_dec;
    logic [7:0]                       dis_dec;
    logic [pbrle_pkg::LimitWidth-1:0] run_ext;
    logic [7:0]                       run_count;
    logic [7:0]                       charge;
    logic [pbrle_pkg::LimitWidth-1:0] owed_after;
    logic                             done;

    assign lit_dec   = state.literal_left - 8'd1;
    assign dis_dec   = state.discard_left - 8'd1;
    assign run_ext   = {{(pbrle_pkg::LimitWidth-8){1'b0}}, state.run_length};
    // run is clipped to what the read still owes
    assign run_count = (run_ext < state.owed) ? state.run_length : state.owed[7:0];
    assign charge    = (state.phase == pbrle_pkg::PH_RUNVAL) ? run_count : 8'd1;
    assign owed_after = state.owed - {{(pbrle_pkg::LimitWidth-8){1'b0}}, charge};
    assign done      = (owed_after == '0);

    always_comb begin
        state_next   = state;
        result.valid = 1'b0;
        result.data  = in_byte;
        result.count = charge;
        result.last  = done;
        unique case (state.phase)
            pbrle_pkg::PH_HEADER: begin
                if (in_byte == pbrle_pkg::HDR_NOP) begin
                    state_next.phase = pbrle_pkg::PH_HEADER;
                end else if (!in_byte[7]) begin
                    state_next.literal_left = in_byte + 8'd1;
                    state_next.phase        = pbrle_pkg::PH_LITERAL;
                end else begin
                    // 257 - n, modulo 256 since n >= 129
                    state_next.run_length = 8'd1 - in_byte;
                    state_next.phase      = pbrle_pkg::PH_RUNVAL;
                end
            end
            pbrle_pkg::PH_LITERAL: begin
                result.valid            = 1'b1;
                state_next.literal_left = lit_dec;
                state_next.owed         = done ? limit_eff : owed_after;
                if (lit_dec == 8'd0) begin
                    state_next.phase = pbrle_pkg::PH_HEADER;
                end else if (done) begin
                    state_next.discard_left = lit_dec;
                    state_next.literal_left = 8'd0;
                    state_next.phase        = pbrle_pkg::PH_DISCARD;
                end
            end
            pbrle_pkg::PH_DISCARD: begin
                state_next.discard_left = dis_dec;
                if (dis_dec == 8'd0) begin
                    state_next.phase = pbrle_pkg::PH_HEADER;
                end
            end
            pbrle_pkg::PH_RUNVAL: begin
                result.valid          = 1'b1;
                state_next.owed       = done ? limit_eff : owed_after;
                state_next.run_length = 8'd0;
                state_next.phase      = pbrle_pkg::PH_HEADER;
            end
            default: begin
                state_next.phase = pbrle_pkg::PH_HEADER;
            end
        endcase
    end

endmodule

// ===== rtl/core/packbits_rle_decoder.sv =====
// ----------------------------------------------------------------------------
// PackBits run-length decoder
// Stream decoder, one compressed byte per word, clipped to a read length.
// ----------------------------------------------------------------------------
// Takes one compressed byte per input word and emits at most one result word
// per input: a decoded byte plus a repeat count (1 for literals, up to 128 for
// runs). Header and no-op bytes and dropped literal tails give no result. The
// output limit register sets how many decoded bytes one read delivers; the
// result that completes it carries m_tlast, and the count then reloads. A
// limit of zero acts as one, and writing the limit restarts the current read.
// Write the limit only while the decoder is idle. Throughput is one word per
// cycle while m_tready drains the result register; words pass the input
// register, the combinational decode step and the result register. The output
// register frees the input side while a finished result waits on m_tready.
// ----------------------------------------------------------------------------
module packbits_rle_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [15:8] repeat_count
    output logic        m_tlast,   // end_of_read
    // output limit write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [pbrle_pkg::LimitWidth-1:0] cfg_data
);

    // config
    logic [pbrle_pkg::LimitWidth-1:0] limit_reg;
    logic [pbrle_pkg::LimitWidth-1:0] limit_eff;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // decode state
    pbrle_pkg::dec_state_t  state_reg;
    pbrle_pkg::dec_state_t  state_next;
    pbrle_pkg::dec_result_t result;

    // result register
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic [7:0] out_count_reg;
    logic       out_last_reg;

    logic out_free;
    logic advance;

    assign cfg_ready = 1'b1;
    assign limit_eff = (limit_reg == '0) ? {{(pbrle_pkg::LimitWidth-1){1'b0}}, 1'b1}
                                         : limit_reg;

    // Stage moves when it needs no output slot or the slot frees this cycle.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!result.valid || out_free);
    assign s_tready = !in_valid_reg || advance;

    pbrle_step u_step (
        .state      (state_reg),
        .in_byte    (in_byte_reg),
        .limit_eff  (limit_eff),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg              <= pbrle_pkg::LIMIT_RESET;
            in_valid_reg           <= 1'b0;
            state_reg.phase        <= pbrle_pkg::PH_HEADER;
            state_reg.literal_left <= 8'd0;
            state_reg.discard_left <= 8'd0;
            state_reg.run_length   <= 8'd0;
            state_reg.owed         <= pbrle_pkg::LIMIT_RESET;
            out_valid_reg          <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                state_reg <= state_next;
            end
            // limit write restarts the read; decode phase is kept
            if (cfg_valid) begin
                limit_reg <= cfg_data;
                state_reg.owed <= (cfg_data == '0)
                    ? {{(pbrle_pkg::LimitWidth-1){1'b0}}, 1'b1} : cfg_data;
            end
            if (advance && result.valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
        if (advance && result.valid) begin
            out_byte_reg  <= result.data;
            out_count_reg <= result.count;
            out_last_reg  <= result.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/core/pbrle_checker.sv =====
// ----------------------------------------------------------------------------
// PackBits decoder port checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "packbits_rle_decoder_macros.svh"

module pbrle_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // a stalled word keeps its contents
    `PBRLE_ASSERT_RUN(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // repeat count always within 1..128
    `PBRLE_ASSERT_RUN(a_count_range, m_tvalid |-> (m_tdata[15:8] != 8'd0) && (m_tdata[15:8] <= 8'd128))

    // reset empties the result stage
    `PBRLE_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid)

endmodule

bind packbits_rle_decoder pbrle_checker u_pbrle_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== sim/packbits_rle_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PackBits decoder testbench
// Streams compressed bytes into the decoder under random stalls on both sides
// and checks every result word against a cycle-free software decoder.
// ----------------------------------------------------------------------------
module packbits_rle_decoder_tb;

    localparam int LimitWidth = pbrle_pkg::LimitWidth;

    // cycles to let the pipe settle once nothing is expected
    localparam int SETTLE_CYCLES  = 6;
    // long receiver stall used to fill the pipe and stall the input side
    localparam int RX_HOLD_CYCLES = 200;
    // watchdog: cycles in a row with no handshake on any channel
    localparam int STALL_LIMIT    = 1000;
    localparam int MAX_REPORTS    = 20;
    localparam logic [LimitWidth-1:0] LIMIT_MAX = '1;

    // expected result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic [7:0] repeat_count;
        logic       end_of_read;
    } decoded_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;   // [7:0] in_byte
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;        // [7:0] out_byte, [15:8] repeat_count
    logic                  m_tlast;        // end_of_read
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [LimitWidth-1:0] cfg_data = '0;

    packbits_rle_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Decoder state mirror, updated only by the monitor below
    // ------------------------------------------------------------------------
    pbrle_pkg::phase_t     dec_phase;
    logic [7:0]            lit_left;
    logic [7:0]            drop_left;
    logic [7:0]            run_len;
    logic [LimitWidth-1:0] owed;
    logic [LimitWidth-1:0] read_limit;

    decoded_word_t pending_words[$];

    // knobs for the stimulus processes
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit rx_hold_req = 1'b0;

    int bytes_sent = 0;
    int words_checked = 0;
    int reads_done = 0;
    int limits_written = 0;
    int errors = 0;

    // Charge cnt decoded bytes to the current read; 1 when the read completes.
    function automatic logic charge_read(input logic [LimitWidth-1:0] cnt);
        owed = owed - cnt;
        if (owed == '0) begin
            // a zero limit behaves as one
            owed = (read_limit == '0) ? LimitWidth'(1) : read_limit;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the mirror by one compressed byte, queueing any result word.
    function automatic void decode_in_byte(input logic [7:0] b);
        decoded_word_t w;
        logic [7:0] cnt;
        case (dec_phase)
            pbrle_pkg::PH_HEADER: begin
                if (b == pbrle_pkg::HDR_NOP) begin
                    // no-op header, stay here
                end else if (b <= 8'd127) begin
                    lit_left  = b + 8'd1;
                    dec_phase = pbrle_pkg::PH_LITERAL;
                end else begin
                    run_len   = 8'(9'd257 - {1'b0, b});
                    dec_phase = pbrle_pkg::PH_RUNVAL;
                end
            end
            pbrle_pkg::PH_LITERAL: begin
                lit_left = lit_left - 8'd1;
                w.out_byte     = b;
                w.repeat_count = 8'd1;
                w.end_of_read  = charge_read(LimitWidth'(1));
                pending_words.push_back(w);
                if (lit_left == 8'd0) begin
                    dec_phase = pbrle_pkg::PH_HEADER;
                end else if (w.end_of_read) begin
                    // read ended mid-literal: swallow the tail silently
                    drop_left = lit_left;
                    lit_left  = 8'd0;
                    dec_phase = pbrle_pkg::PH_DISCARD;
                end
            end
            pbrle_pkg::PH_DISCARD: begin
                drop_left = drop_left - 8'd1;
                if (drop_left == 8'd0) dec_phase = pbrle_pkg::PH_HEADER;
            end
            default: begin
                // run clipped to what the read still owes
                cnt = (LimitWidth'(run_len) < owed) ? run_len : owed[7:0];
                w.out_byte     = b;
                w.repeat_count = cnt;
                w.end_of_read  = charge_read(LimitWidth'(cnt));
                pending_words.push_back(w);
                run_len   = 8'd0;
                dec_phase = pbrle_pkg::PH_HEADER;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: predicts on input words and limit writes, checks result words
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        decoded_word_t w;
        if (!aresetn) begin
            dec_phase  = pbrle_pkg::PH_HEADER;
            lit_left   = '0;
            drop_left  = '0;
            run_len    = '0;
            read_limit = pbrle_pkg::LIMIT_RESET;
            owed       = pbrle_pkg::LIMIT_RESET;
            pending_words.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                // a limit write restarts the read but keeps the decode phase
                read_limit = cfg_data;
                owed = (cfg_data == '0) ? LimitWidth'(1) : cfg_data;
            end
            if (s_tvalid && s_tready) decode_in_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                if (pending_words.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected result word tdata %04h tlast %0b",
                                 $time, m_tdata, m_tlast);
                end else begin
                    w = pending_words.pop_front();
                    words_checked++;
                    if (w.end_of_read) reads_done++;
                    if (m_tdata[7:0] !== w.out_byte) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: out_byte expected %02h actual %02h",
                                     $time, w.out_byte, m_tdata[7:0]);
                    end
                    if (m_tdata[15:8] !== w.repeat_count) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: repeat_count expected %0d actual %0d",
                                     $time, w.repeat_count, m_tdata[15:8]);
                    end
                    if (m_tlast !== w.end_of_read) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: end_of_read expected %0b actual %0b",
                                     $time, w.end_of_read, m_tlast);
                    end
                end
            end
        end
    end

    // Watchdog: any accepted word on any channel resets the count.
    always @(posedge aclk) begin
        int quiet_cycles;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, %0d result words still expected",
                     $time, pending_words.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: random ready gaps, plus one long hold-off on request.
    initial begin
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold_req = 1'b0;
            end else begin
                gap = rx_idle_on ? $urandom_range(0, 5) : 0;
                if (gap != 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // ------------------------------------------------------------------------
    // Shared driver tasks
    // ------------------------------------------------------------------------

    // Offer one compressed byte; tvalid stays up afterwards so back-to-back
    // bytes need no extra edge. Whoever stops sending drops it.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 5) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    // Stop sending, wait out every expected word, then let the pipe settle.
    // Checked on the falling edge so the monitor's update is already in.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_words.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Only called with the decoder idle (after drain).
    task automatic write_limit(input logic [LimitWidth-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        limits_written++;
    endtask

    // One random packet: mostly well-formed literal and run packets with
    // random content, some no-ops and some raw noise that breaks framing.
    task automatic send_packet();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 7);
            send_byte(8'(n));
            repeat (n + 1) send_byte(8'($urandom_range(0, 255)));
        end else if (kind < 85) begin
            send_byte(8'($urandom_range(129, 255)));
            send_byte(8'($urandom_range(0, 255)));
        end else if (kind < 90) begin
            send_byte(pbrle_pkg::HDR_NOP);
        end else begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Every header kind at the reset limit: shortest literal, two-byte literal,
    // no-op, longest and shortest runs, extreme data values.
    task automatic test_packet_kinds();
        send_byte(8'h00); send_byte(8'hFF);
        send_byte(8'h01); send_byte(8'h00); send_byte(8'hA5);
        send_byte(pbrle_pkg::HDR_NOP);
        send_byte(8'h81); send_byte(8'h5A);
        send_byte(8'hFF); send_byte(8'h00);
    endtask

    // Literal cut short by the limit (tail dropped), run clipped to the owed
    // count, then a zero limit that behaves as one.
    task automatic test_limit_cuts();
        drain();
        write_limit(LimitWidth'(2));
        send_byte(8'h03);
        send_byte(8'h11); send_byte(8'h22); send_byte(8'h33); send_byte(8'h44);
        send_byte(8'h81); send_byte(8'h77);
        drain();
        write_limit('0);
        send_byte(8'h01); send_byte(8'hAA); send_byte(8'hBB);
        send_byte(8'h83); send_byte(8'hCC);
    endtask

    // A limit write in the middle of a literal packet keeps the packet going
    // and restarts the read count.
    task automatic test_limit_write_mid_packet();
        drain();
        write_limit(LimitWidth'(5));
        send_byte(8'h04); send_byte(8'h01); send_byte(8'h02);
        drain();
        write_limit(LimitWidth'(3));
        send_byte(8'h03); send_byte(8'h04); send_byte(8'h05);
    endtask

    // Receiver stalls for a long stretch while a maximal literal streams in,
    // so the pipe fills and backs up the input; then the sender waits for all.
    task automatic test_backpressure();
        drain();
        write_limit(LIMIT_MAX);
        tx_idle_on  = 1'b0;
        rx_hold_req = 1'b1;
        send_byte(8'h7F);
        repeat (128) send_byte(8'($urandom_range(0, 255)));
        drain();
        tx_idle_on = 1'b1;
    endtask

    task automatic test_random_traffic(input int n_bytes, input logic [LimitWidth-1:0] limit,
                                       input bit tx_idle, input bit rx_idle);
        int stop_at;
        drain();
        write_limit(limit);
        tx_idle_on = tx_idle;
        rx_idle_on = rx_idle;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) send_packet();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_packet_kinds();
        test_limit_cuts();
        test_limit_write_mid_packet();
        test_backpressure();

        test_random_traffic(250, pbrle_pkg::LIMIT_RESET, 1'b1, 1'b1);
        test_random_traffic(200, LimitWidth'(1), 1'b1, 1'b0);
        test_random_traffic(100, '0, 1'b0, 1'b1);
        test_random_traffic(250, LIMIT_MAX, 1'b1, 1'b0);
        test_random_traffic(300, LimitWidth'($urandom_range(2, 40)), 1'b0, 1'b0);
        test_random_traffic(300, LimitWidth'($urandom_range(1, 300)), 1'b1, 1'b1);
        test_random_traffic(100, LimitWidth'($urandom), 1'b1, 1'b1);

        drain();
        errors += pending_words.size();
        $display("covered %0d compressed bytes, %0d result words, %0d completed reads",
                 bytes_sent, words_checked, reads_done);
        $display("across %0d output limit writes incl. 0, 1 and the 24-bit maximum",
                 limits_written);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
